FILE: src/ini_line_tokenizer_macros.svh
// Assertion macros for the INI line tokenizer.
`ifndef INI_LINE_TOKENIZER_MACROS_SVH
`define INI_LINE_TOKENIZER_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ILT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ini_line_tokenizer: assertion failed");

// Condition must never be seen outside reset.
`define ILT_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("ini_line_tokenizer: forbidden condition seen");

`else

`define ILT_ASSERT(label, clk, rst, prop)
`define ILT_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

FILE: src/ilt_pkg.sv
// Shared types, constants and codes of the INI line tokenizer.
package ilt_pkg;

   localparam int MAX_TOKEN = 256;
   localparam logic [7:0] LIMIT_CAP = 8'(MAX_TOKEN - 1);

   localparam int FIFO_DEPTH = 8;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_VALUE_SEPARATOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TOKEN_LIMIT     = 2'd1;

   localparam logic [7:0] SEP_RESET   = 8'd44;
   localparam logic [7:0] LIMIT_RESET = 8'd255;

   localparam logic [1:0] KIND_SECTION    = 2'd0;
   localparam logic [1:0] KIND_HEAD       = 2'd1;
   localparam logic [1:0] KIND_VALUE      = 2'd2;
   localparam logic [1:0] KIND_STREAM_END = 2'd3;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_EQUALS  = 8'h3D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;

   typedef enum logic [6:0] {
      MODE_START    = 7'b0000001,
      MODE_SKIP     = 7'b0000010,
      MODE_SEC_LEAD = 7'b0000100,
      MODE_SEC_BODY = 7'b0001000,
      MODE_HEAD     = 7'b0010000,
      MODE_VAL_LEAD = 7'b0100000,
      MODE_VAL_BODY = 7'b1000000
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic        term_run;
      logic [7:0]  kept_length;
      logic [7:0]  pending_blanks;
      logic        after_sep;
      logic [15:0] section_count;
   } state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        has_char;
      logic [7:0]  char_out;
      logic [7:0]  blanks_before;
      logic        token_end;
      logic        head_is_key;
      logic [15:0] section_total;
      logic        last;
   } rsp_type;

   localparam state_type STATE_RESET = '{
      mode:           MODE_START,
      term_run:       1'b0,
      kept_length:    8'd0,
      pending_blanks: 8'd0,
      after_sep:      1'b0,
      section_count:  16'd0
   };

endpackage

FILE: src/ini_line_tokenizer.sv
// Top level of the INI line tokenizer: request register, line state, result queue.
//
// Usage:
//   Request channel (req_): one text byte per request; byte 0 ends the stream.
//   Result channel (rsp_): token bytes, token ends and the stream-end report.
//   A byte gives zero, one or two results; rsp_last marks the final one.
//   csr_: write value_separator (index 0) or token_limit (index 1) while idle.
// Path: an accepted byte is held in the request register; its results are then
//   written into the result queue, which presents them on rsp_.
// Throughput: one byte per cycle while req_stall is low; results waiting in the
//   queue count toward req_stall. The 8-entry result queue and the request
//   register set the rate: req_stall rises only when the queue could not take
//   the results of the bytes in flight.
// Reset: line state, section count and queue are cleared; the separator
//   returns to ',' and the token limit to 255.
// Receiver stall: results hold in the queue; req_stall rises once it nears
//   full and falls once enough results have been taken to make room again.
`include "ini_line_tokenizer_macros.svh"

module ini_line_tokenizer import ilt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_data_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_kind,
   output logic                 rsp_has_char,
   output logic [7:0]           rsp_char_out,
   output logic [7:0]           rsp_blanks_before,
   output logic                 rsp_token_end,
   output logic                 rsp_head_is_key,
   output logic [15:0]          rsp_section_total,
   output logic                 rsp_last,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wr_data
);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   state_type        state_ff, state_in;
   logic [7:0]       sep_ff;
   logic [7:0]       limit_ff;
   state_type        step_next;
   rsp_type          res0, res1, head;
   logic [1:0]       res_count;
   logic [1:0]       push_count;
   logic             fifo_not_empty;
   logic [CNT_W-1:0] fifo_count;
   logic [CNT_W:0]   need;
   logic             req_accept;
   logic             pop;
   logic             nul_in_reg;
   logic             state_cleared;
   logic             stream_end_out;
   logic             stream_end_bare;
   logic             char_out_seen;
   logic             char_ok;

   assign need = {1'b0, fifo_count} + (in_valid_ff ? (CNT_W + 1)'(2) : '0)
               + (CNT_W + 1)'(2);
   assign req_stall = need > (CNT_W + 1)'(FIFO_DEPTH);
   assign req_accept = req_valid && !req_stall;
   assign in_valid_in = req_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff <= SEP_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == REG_VALUE_SEPARATOR) begin
            sep_ff <= csr_wr_data;
         end else if (csr_index == REG_TOKEN_LIMIT) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   ilt_step u_step (
      .data_byte       (in_byte_ff),
      .state           (state_ff),
      .value_separator (sep_ff),
      .token_limit     (limit_ff),
      .state_next      (step_next),
      .res0            (res0),
      .res1            (res1),
      .res_count       (res_count)
   );

   assign state_in = in_valid_ff ? step_next : state_ff;
   assign push_count = in_valid_ff ? res_count : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   ilt_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (res0),
      .push1      (res1),
      .pop        (pop),
      .head       (head),
      .not_empty  (fifo_not_empty),
      .count      (fifo_count)
   );

   assign rsp_valid = fifo_not_empty;
   assign pop = rsp_valid && !rsp_stall;

   assign rsp_kind = head.kind;
   assign rsp_has_char = head.has_char;
   assign rsp_char_out = head.char_out;
   assign rsp_blanks_before = head.blanks_before;
   assign rsp_token_end = head.token_end;
   assign rsp_head_is_key = head.head_is_key;
   assign rsp_section_total = head.section_total;
   assign rsp_last = head.last;

   assign nul_in_reg = in_valid_ff && in_byte_ff == CH_NUL;
   assign state_cleared = state_ff.mode == MODE_START && state_ff.section_count == 16'd0;
   assign stream_end_out = rsp_valid && rsp_kind == KIND_STREAM_END;
   assign stream_end_bare = !rsp_has_char && !rsp_token_end && rsp_last;
   assign char_out_seen = rsp_valid && rsp_has_char;
   assign char_ok = rsp_char_out != CH_NUL && !rsp_token_end;

   `ILT_ASSERT_NEVER(a_fifo_no_overflow, clock, reset, fifo_count > CNT_W'(FIFO_DEPTH))

   `ILT_ASSERT(a_end_clears_state, clock, reset, nul_in_reg |=> state_cleared)

   `ILT_ASSERT(a_stream_end_bare, clock, reset, stream_end_out |-> stream_end_bare)

   `ILT_ASSERT(a_char_not_nul, clock, reset, char_out_seen |-> char_ok)

endmodule

FILE: src/ilt_step.sv
// Per-byte line classification: next state and up to two results.
module ilt_step import ilt_pkg::*; (
   input  logic [7:0] data_byte,
   input  state_type  state,
   input  logic [7:0] value_separator,
   input  logic [7:0] token_limit,
   output state_type  state_next,
   output rsp_type    res0,
   output rsp_type    res1,
   output logic [1:0] res_count
);

   function automatic rsp_type end_res(input logic [1:0] kind, input logic key);
      rsp_type r;
      r = '0;
      r.kind = kind;
      r.token_end = 1'b1;
      r.head_is_key = key;
      return r;
   endfunction

   function automatic rsp_type char_res(input logic [1:0] kind, input logic [7:0] ch,
                                        input logic [7:0] blanks);
      rsp_type r;
      r = '0;
      r.kind = kind;
      r.has_char = 1'b1;
      r.char_out = ch;
      r.blanks_before = blanks;
      return r;
   endfunction

   logic [7:0] lim;
   logic       room;
   logic       blank;
   logic       line_end;
   rsp_type    end_r;
   logic       has_end;
   rsp_type    stream_r;

   always_comb begin
      lim = (token_limit > LIMIT_CAP) ? LIMIT_CAP : token_limit;
      room = state.kept_length < lim;
      blank = data_byte inside {CH_SPACE, CH_TAB};
      line_end = data_byte inside {CH_CR, CH_LF};
      state_next = state;
      res0 = '0;
      res1 = '0;
      res_count = 2'd0;
      end_r = '0;
      has_end = 1'b0;
      stream_r = '0;

      if (data_byte == CH_NUL) begin
         case (state.mode)
            MODE_SEC_LEAD, MODE_SEC_BODY: begin
               end_r = end_res(KIND_SECTION, 1'b0);
               has_end = 1'b1;
            end
            MODE_HEAD: begin
               end_r = end_res(KIND_HEAD, 1'b0);
               has_end = 1'b1;
            end
            MODE_VAL_LEAD, MODE_VAL_BODY: begin
               end_r = end_res(KIND_VALUE, 1'b0);
               has_end = !state.after_sep;
            end
            default: begin
               has_end = 1'b0;
            end
         endcase
         stream_r.kind = KIND_STREAM_END;
         stream_r.section_total = state.section_count;
         if (has_end) begin
            res0 = end_r;
            res1 = stream_r;
            res_count = 2'd2;
         end else begin
            res0 = stream_r;
            res_count = 2'd1;
         end
         state_next = STATE_RESET;
      end else if (line_end) begin
         case (state.mode)
            MODE_START: begin
               res0 = end_res(KIND_HEAD, 1'b0);
               res_count = state.term_run ? 2'd0 : 2'd1;
            end
            MODE_SEC_LEAD, MODE_SEC_BODY: begin
               res0 = end_res(KIND_SECTION, 1'b0);
               res_count = 2'd1;
            end
            MODE_HEAD: begin
               res0 = end_res(KIND_HEAD, 1'b0);
               res_count = 2'd1;
            end
            MODE_VAL_LEAD, MODE_VAL_BODY: begin
               res0 = end_res(KIND_VALUE, 1'b0);
               res_count = state.after_sep ? 2'd0 : 2'd1;
            end
            default: begin
               res_count = 2'd0;
            end
         endcase
         state_next.mode = MODE_START;
         state_next.term_run = 1'b1;
         state_next.after_sep = 1'b0;
         state_next.kept_length = 8'd0;
         state_next.pending_blanks = 8'd0;
      end else begin
         state_next.term_run = 1'b0;
         state_next.after_sep = 1'b0;
         case (state.mode)
            MODE_START: begin
               if (blank) begin
                  state_next.mode = MODE_START;
               end else if (data_byte == CH_HASH) begin
                  state_next.mode = MODE_SKIP;
               end else if (data_byte == CH_LBRACK) begin
                  if (state.section_count != 16'hFFFF) begin
                     state_next.section_count = state.section_count + 16'd1;
                  end
                  state_next.kept_length = 8'd0;
                  state_next.pending_blanks = 8'd0;
                  state_next.mode = MODE_SEC_LEAD;
               end else if (data_byte == CH_EQUALS) begin
                  res0 = end_res(KIND_HEAD, 1'b1);
                  res_count = 2'd1;
                  state_next.kept_length = 8'd0;
                  state_next.pending_blanks = 8'd0;
                  state_next.mode = MODE_VAL_LEAD;
               end else begin
                  state_next.mode = MODE_HEAD;
                  state_next.pending_blanks = 8'd0;
                  if (lim != 8'd0) begin
                     state_next.kept_length = 8'd1;
                     res0 = char_res(KIND_HEAD, data_byte, 8'd0);
                     res_count = 2'd1;
                  end else begin
                     state_next.kept_length = 8'd0;
                  end
               end
            end
            MODE_SEC_LEAD, MODE_SEC_BODY: begin
               if (data_byte == CH_RBRACK) begin
                  res0 = end_res(KIND_SECTION, 1'b0);
                  res_count = 2'd1;
                  state_next.kept_length = 8'd0;
                  state_next.pending_blanks = 8'd0;
                  state_next.mode = MODE_SKIP;
               end else if (blank) begin
                  if (state.mode == MODE_SEC_BODY && room) begin
                     state_next.kept_length = state.kept_length + 8'd1;
                     state_next.pending_blanks = state.pending_blanks + 8'd1;
                  end
               end else begin
                  state_next.mode = MODE_SEC_BODY;
                  if (room) begin
                     state_next.kept_length = state.kept_length + 8'd1;
                     state_next.pending_blanks = 8'd0;
                     res0 = char_res(KIND_SECTION, data_byte, state.pending_blanks);
                     res_count = 2'd1;
                  end
               end
            end
            MODE_HEAD: begin
               if (data_byte == CH_EQUALS) begin
                  res0 = end_res(KIND_HEAD, 1'b1);
                  res_count = 2'd1;
                  state_next.kept_length = 8'd0;
                  state_next.pending_blanks = 8'd0;
                  state_next.mode = MODE_VAL_LEAD;
               end else if (blank) begin
                  if (room) begin
                     state_next.kept_length = state.kept_length + 8'd1;
                     state_next.pending_blanks = state.pending_blanks + 8'd1;
                  end
               end else if (room) begin
                  state_next.kept_length = state.kept_length + 8'd1;
                  state_next.pending_blanks = 8'd0;
                  res0 = char_res(KIND_HEAD, data_byte, state.pending_blanks);
                  res_count = 2'd1;
               end
            end
            MODE_VAL_LEAD: begin
               if (blank) begin
                  state_next.mode = MODE_VAL_LEAD;
               end else if (data_byte == value_separator) begin
                  res0 = end_res(KIND_VALUE, 1'b0);
                  res_count = 2'd1;
                  state_next.kept_length = 8'd0;
                  state_next.pending_blanks = 8'd0;
                  state_next.after_sep = 1'b1;
               end else begin
                  state_next.mode = MODE_VAL_BODY;
                  if (room) begin
                     state_next.kept_length = state.kept_length + 8'd1;
                     state_next.pending_blanks = 8'd0;
                     res0 = char_res(KIND_VALUE, data_byte, state.pending_blanks);
                     res_count = 2'd1;
                  end
               end
            end
            MODE_VAL_BODY: begin
               if (data_byte == value_separator) begin
                  res0 = end_res(KIND_VALUE, 1'b0);
                  res_count = 2'd1;
                  state_next.kept_length = 8'd0;
                  state_next.pending_blanks = 8'd0;
                  state_next.after_sep = 1'b1;
                  state_next.mode = MODE_VAL_LEAD;
               end else if (blank) begin
                  if (room) begin
                     state_next.kept_length = state.kept_length + 8'd1;
                     state_next.pending_blanks = state.pending_blanks + 8'd1;
                  end
               end else if (room) begin
                  state_next.kept_length = state.kept_length + 8'd1;
                  state_next.pending_blanks = 8'd0;
                  res0 = char_res(KIND_VALUE, data_byte, state.pending_blanks);
                  res_count = 2'd1;
               end
            end
            default: begin
               state_next.mode = MODE_SKIP;
            end
         endcase
      end

      if (res_count == 2'd2) begin
         res1.last = 1'b1;
      end else if (res_count == 2'd1) begin
         res0.last = 1'b1;
      end
   end

endmodule

FILE: src/ilt_rsp_fifo.sv
// Result queue: takes up to two results a cycle, delivers one per pop.
module ilt_rsp_fifo import ilt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_count,
   input  rsp_type          push0,
   input  rsp_type          push1,
   input  logic             pop,
   output rsp_type          head,
   output logic             not_empty,
   output logic [CNT_W-1:0] count
);

   rsp_type          mem [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_ptr_plus1;

   assign wr_ptr_plus1 = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff + CNT_W'(push_count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem[wr_ptr_plus1] <= push1;
      end
   end

   assign head = mem[rd_ptr_ff];
   assign not_empty = count_ff != '0;
   assign count = count_ff;

endmodule
